FILE: rtl/i2crf_pkg.sv
package i2crf_pkg;

    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_BYTE     = 3'd1;
    localparam logic [2:0] CMD_ACK_SLOT = 3'd2;
    localparam logic [2:0] CMD_HWRITE   = 3'd3;
    localparam logic [2:0] CMD_HREAD    = 3'd4;
    localparam logic [2:0] CMD_HCLEAR   = 3'd5;

    localparam logic CFG_OWN_ADDR = 1'b0;
    localparam logic CFG_WR_MASK  = 1'b1;

    localparam int ADDR_RW_BIT = 0;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] bus_byte;
        logic       master_nack;
        logic [2:0] host_index;
        logic [7:0] host_data;
    } t_in;

    typedef struct packed {
        logic       ack;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [7:0] host_read_data;
        logic [7:0] changed_bits;
    } t_out;

endpackage

FILE: rtl/i2c_target_register_file_top.sv
// Channel | Valid      | Stall       | Payload
// --------+------------+-------------+-------------------------------
// input   | i_in_valid | o_in_stall  | i_in  (i2crf_pkg::t_in)
// output  | o_out_valid| i_out_stall | o_out (i2crf_pkg::t_out)
// config  | i_cfg_we   | -           | i_cfg_index, i_cfg_data
//
// One beat in per cycle while o_in_stall is low; each result passes through the
// register file read in the RAM, then the output register, before it is shown.
// Phase, pointer, changed mask and per-entry valid bits live in flip-flops; an
// entry never written since reset reads as zero. No clearing pass is needed.
// Synchronous active-low reset. Output stall backs up through one pending stage.
module i2c_target_register_file_top #(
    parameter int REG_COUNT = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_index,
    input  logic [7:0]      i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  i2crf_pkg::t_in  i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output i2crf_pkg::t_out o_out
);

    import i2crf_pkg::*;

    localparam int PW         = $clog2(REG_COUNT);
    localparam int SLOT_RECIP = (2048 + REG_COUNT - 1) / REG_COUNT;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_ADDR   = 5'b00010,
        PH_WINDEX = 5'b00100,
        PH_WDATA  = 5'b01000,
        PH_READ   = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       ack;
        logic       tx_valid;
        logic       sel_tx;
        logic       sel_hrd;
        logic       hit;
        logic [7:0] changed;
    } t_s1;

    // Reduce by reciprocal multiplication; exact for every 8-bit value.
    function automatic logic [PW-1:0] f_slot(input logic [7:0] n);
        logic [18:0] prod;
        logic [7:0]  quot;
        logic [7:0]  rest;
        prod = {11'd0, n} * 19'(SLOT_RECIP);
        quot = prod[18:11];
        rest = n - 8'(quot * 8'(REG_COUNT));
        return rest[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] s);
        if (s == PW'(REG_COUNT - 1)) begin
            return '0;
        end
        return s + PW'(1);
    endfunction

    logic [6:0]           r_own;
    logic [7:0]           r_wmask;
    t_phase               r_phase, n_phase;
    logic [PW-1:0]        r_ptr, n_ptr;
    logic [7:0]           r_chg, n_chg;
    logic [REG_COUNT-1:0] r_vld;
    logic                 r_s1_valid;
    t_s1                  r_s1, n_s1;
    logic                 r_out_valid;
    t_out                 r_out;

    logic          accept, s1_move;
    logic          ram_we, ram_re;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata, rd_val, bit_sel;

    assign s1_move    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_phase   = r_phase;
        n_ptr     = r_ptr;
        n_chg     = r_chg;
        n_s1      = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_ptr;
        ram_raddr = r_ptr;
        ram_wdata = i_in.bus_byte;
        bit_sel   = 8'd1 << r_ptr;
        if (accept) begin
            unique case (i_in.command)
                CMD_START: begin
                    n_phase = PH_ADDR;
                end
                CMD_BYTE: begin
                    unique case (r_phase)
                        PH_ADDR: begin
                            if (i_in.bus_byte[7:1] == r_own) begin
                                n_s1.ack = 1'b1;
                                if (i_in.bus_byte[ADDR_RW_BIT]) begin
                                    n_phase       = PH_READ;
                                    n_s1.tx_valid = 1'b1;
                                    n_s1.sel_tx   = 1'b1;
                                    ram_re        = 1'b1;
                                    n_ptr         = f_next(r_ptr);
                                end else begin
                                    n_phase = PH_WINDEX;
                                end
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_WINDEX: begin
                            n_ptr    = f_slot(i_in.bus_byte);
                            n_phase  = PH_WDATA;
                            n_s1.ack = 1'b1;
                        end
                        PH_WDATA: begin
                            if ((r_wmask & bit_sel) != 8'd0) begin
                                ram_we = 1'b1;
                                n_chg  = r_chg | bit_sel;
                            end
                            n_ptr    = f_next(r_ptr);
                            n_s1.ack = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_ACK_SLOT: begin
                    if (r_phase == PH_READ) begin
                        if (i_in.master_nack) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_s1.tx_valid = 1'b1;
                            n_s1.sel_tx   = 1'b1;
                            ram_re        = 1'b1;
                            n_ptr         = f_next(r_ptr);
                        end
                    end
                end
                CMD_HWRITE: begin
                    ram_we    = 1'b1;
                    ram_waddr = f_slot({5'b00000, i_in.host_index});
                    ram_wdata = i_in.host_data;
                end
                CMD_HREAD: begin
                    ram_re       = 1'b1;
                    ram_raddr    = f_slot({5'b00000, i_in.host_index});
                    n_s1.sel_hrd = 1'b1;
                end
                CMD_HCLEAR: begin
                    n_s1.changed = r_chg;
                    n_chg        = '0;
                end
                default: begin
                end
            endcase
        end
        n_s1.hit = r_vld[ram_raddr];
    end

    i2crf_ram #(
        .WIDTH (8),
        .DEPTH (REG_COUNT)
    ) u_regs (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_val = r_s1.hit ? ram_rdata : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own       <= '0;
            r_wmask     <= '0;
            r_phase     <= PH_IDLE;
            r_ptr       <= '0;
            r_chg       <= '0;
            r_vld       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OWN_ADDR: r_own   <= i_cfg_data[6:0];
                    CFG_WR_MASK:  r_wmask <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_phase <= n_phase;
            r_ptr   <= n_ptr;
            r_chg   <= n_chg;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_move && r_s1_valid) begin
            r_out.ack            <= r_s1.ack;
            r_out.tx_valid       <= r_s1.tx_valid;
            r_out.tx_byte        <= r_s1.sel_tx ? rd_val : 8'd0;
            r_out.host_read_data <= r_s1.sel_hrd ? rd_val : 8'd0;
            r_out.changed_bits   <= r_s1.changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/i2crf_ram.sv
module i2crf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: verif/i2c_target_register_file_top_test.sv
`timescale 1ns / 100ps

module i2c_target_register_file_top_test;
    import i2crf_pkg::*;

    localparam int REG_COUNT    = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 100;
    localparam int PHASE_BEATS  = 200;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_ADDR,
        BUS_WINDEX,
        BUS_WDATA,
        BUS_READ
    } t_bus_phase;

    class i2crf_scoreboard;
        logic [6:0] own_addr;
        logic [7:0] wr_mask;
        t_bus_phase phase;
        logic [7:0] pointer;
        logic [7:0] regs [REG_COUNT];
        logic [7:0] changed;
        t_out       expected_q [$];
        int         fail_count;
        int         result_count;

        function new();
            own_addr     = '0;
            wr_mask      = '0;
            phase        = BUS_IDLE;
            pointer      = '0;
            changed      = '0;
            fail_count   = 0;
            result_count = 0;
            foreach (regs[i]) regs[i] = '0;
        endfunction

        function void set_register(input logic index, input logic [7:0] value);
            if (index == CFG_OWN_ADDR) begin
                own_addr = value[6:0];
            end else begin
                wr_mask = value;
            end
        endfunction

        function logic [7:0] next_tx_byte();
            int slot;
            slot    = int'(pointer) % REG_COUNT;
            pointer = 8'(slot + 1);
            return regs[slot];
        endfunction

        function void note_beat(input t_in beat);
            t_out result;
            int   slot;
            result = '0;
            case (beat.command)
                CMD_START: begin
                    phase = BUS_ADDR;
                end
                CMD_BYTE: begin
                    case (phase)
                        BUS_ADDR: begin
                            if (beat.bus_byte[7:1] == own_addr) begin
                                result.ack = 1'b1;
                                if (beat.bus_byte[ADDR_RW_BIT]) begin
                                    phase           = BUS_READ;
                                    result.tx_valid = 1'b1;
                                    result.tx_byte  = next_tx_byte();
                                end else begin
                                    phase = BUS_WINDEX;
                                end
                            end else begin
                                phase = BUS_IDLE;
                            end
                        end
                        BUS_WINDEX: begin
                            pointer    = beat.bus_byte;
                            phase      = BUS_WDATA;
                            result.ack = 1'b1;
                        end
                        BUS_WDATA: begin
                            slot = int'(pointer) % REG_COUNT;
                            if (wr_mask[slot]) begin
                                regs[slot]    = beat.bus_byte;
                                changed[slot] = 1'b1;
                            end
                            pointer    = 8'(slot + 1);
                            result.ack = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_ACK_SLOT: begin
                    if (phase == BUS_READ) begin
                        if (beat.master_nack) begin
                            phase = BUS_IDLE;
                        end else begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = next_tx_byte();
                        end
                    end
                end
                CMD_HWRITE: begin
                    regs[int'(beat.host_index) % REG_COUNT] = beat.host_data;
                end
                CMD_HREAD: begin
                    result.host_read_data = regs[int'(beat.host_index) % REG_COUNT];
                end
                CMD_HCLEAR: begin
                    result.changed_bits = changed;
                    changed             = '0;
                end
                default: begin
                end
            endcase
            expected_q.push_back(result);
        endfunction

        task report_mismatch(input string msg);
            if (fail_count < PRINT_LIMIT) begin
                $display("%0t: mismatch on result beat %0d: %s", $realtime, result_count, msg);
            end
            fail_count++;
        endtask

        task compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("%s got %02h, expected %02h", name, got, want));
            end
        endtask

        task check_result(input t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                report_mismatch("result beat with nothing outstanding");
            end else begin
                want = expected_q.pop_front();
                compare_field("ack", 8'(got.ack), 8'(want.ack));
                compare_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
                compare_field("tx_byte", got.tx_byte, want.tx_byte);
                compare_field("host_read_data", got.host_read_data, want.host_read_data);
                compare_field("changed_bits", got.changed_bits, want.changed_bits);
            end
            result_count++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [7:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    i2crf_scoreboard sb;
    int burst_left;
    int beats_sent;

    i2c_target_register_file_top #(
        .REG_COUNT(REG_COUNT)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_in random_beat(input logic [2:0] command);
        t_in beat;
        beat.command     = command;
        beat.bus_byte    = 8'($urandom);
        beat.master_nack = 1'($urandom);
        beat.host_index  = 3'($urandom);
        beat.host_data   = 8'($urandom);
        return beat;
    endfunction

    function automatic logic [7:0] address_byte(input logic read);
        return {sb.own_addr, read};
    endfunction

    task automatic send_beat(input t_in beat);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) begin
                gap = 0;
            end else if ($urandom_range(0, 9) == 0) begin
                gap = $urandom_range(10, 30);
            end else begin
                gap = $urandom_range(1, 4);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in       <= beat;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(beat);
        if (beat.command <= CMD_HCLEAR) beats_sent++;
    endtask

    task automatic send_start();
        send_beat(random_beat(CMD_START));
    endtask

    task automatic send_bus_byte(input logic [7:0] value);
        t_in beat;
        beat          = random_beat(CMD_BYTE);
        beat.bus_byte = value;
        send_beat(beat);
    endtask

    task automatic send_ack_slot(input logic nack);
        t_in beat;
        beat             = random_beat(CMD_ACK_SLOT);
        beat.master_nack = nack;
        send_beat(beat);
    endtask

    task automatic send_host(input logic [2:0] command, input logic [2:0] index,
                             input logic [7:0] data);
        t_in beat;
        beat            = random_beat(command);
        beat.host_index = index;
        beat.host_data  = data;
        send_beat(beat);
    endtask

    task automatic bus_write_burst();
        int count;
        count = $urandom_range(0, 10);
        send_start();
        send_bus_byte(address_byte(1'b0));
        send_bus_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)));
        repeat (count) send_bus_byte(8'($urandom));
    endtask

    task automatic bus_read_burst();
        int count;
        count = $urandom_range(0, 12);
        if ($urandom_range(0, 1) == 1) begin
            send_start();
            send_bus_byte(address_byte(1'b0));
            send_bus_byte(8'($urandom));
        end
        send_start();
        send_bus_byte(address_byte(1'b1));
        repeat (count) begin
            if ($urandom_range(0, 7) == 0) send_bus_byte(8'($urandom));
            send_ack_slot(1'b0);
        end
        if ($urandom_range(0, 7) != 0) send_ack_slot(1'b1);
    endtask

    task automatic run_random_phase(input int target);
        int goal;
        int pick;
        goal = beats_sent + target;
        while (beats_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                bus_write_burst();
            end else if (pick < 75) begin
                bus_read_burst();
            end else if (pick < 90) begin
                send_beat(random_beat(3'($urandom_range(CMD_HWRITE, CMD_HCLEAR))));
            end else if (pick < 95) begin
                send_start();
                send_bus_byte(8'($urandom));
            end else begin
                send_beat(random_beat(3'($urandom)));
            end
        end
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [6:0] own_addr, input logic [7:0] wr_mask);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OWN_ADDR;
        i_cfg_data  <= {1'($urandom), own_addr};
        @(posedge i_clk);
        i_cfg_index <= CFG_WR_MASK;
        i_cfg_data  <= wr_mask;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_register(CFG_OWN_ADDR, {1'b0, own_addr});
        sb.set_register(CFG_WR_MASK, wr_mask);
    endtask

    initial begin
        sb         = new();
        burst_left = 0;
        beats_sent = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_OWN_ADDR;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(7'h7F, 8'hA5);
        send_bus_byte(8'hFE);
        send_ack_slot(1'b0);
        send_start();
        send_bus_byte(8'hFE);
        send_bus_byte(8'hFF);
        send_bus_byte(8'h00);
        send_bus_byte(8'hFF);
        send_bus_byte(8'h3C);
        send_start();
        send_bus_byte(8'hFF);
        send_bus_byte(8'h12);
        send_ack_slot(1'b0);
        send_ack_slot(1'b1);
        send_start();
        send_bus_byte(8'h00);
        send_bus_byte(8'h01);
        send_host(CMD_HWRITE, 3'd7, 8'hFF);
        send_host(CMD_HWRITE, 3'd0, 8'h00);
        send_host(CMD_HREAD, 3'd7, 8'h00);
        send_host(CMD_HREAD, 3'd0, 8'hFF);
        send_beat(random_beat(CMD_HCLEAR));
        send_beat(random_beat(CMD_HCLEAR));
        send_beat(random_beat(CMD_SPARE_LO));
        send_beat(random_beat(CMD_SPARE_HI));
        settle();

        configure(7'h00, 8'h00);
        run_random_phase(PHASE_BEATS);
        settle();
        configure(7'h7F, 8'hFF);
        run_random_phase(PHASE_BEATS);
        settle();
        repeat (6) begin
            configure(7'($urandom), 8'($urandom));
            run_random_phase(PHASE_BEATS);
            settle();
        end

        if (sb.fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  pressure_done;
        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        pressure_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            if (!pressure_done && sb.result_count >= 300) begin
                pressure_done = 1'b1;
                hold_left     = 250;
            end else if (hold_left == 0 && $urandom_range(0, 1999) == 0) begin
                hold_left = $urandom_range(40, 120);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= ((mode_left % 8) < 3);
                endcase
            end
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
